// File: design/sstg_pkg.sv
`default_nettype none

package sstg_pkg;

	// Fixed sizes of the generator
	localparam int unsigned RAMP_LEN        = 30;
	localparam int unsigned SINE_TABLE_BITS = 10;
	localparam int unsigned QUARTER         = 1 << (SINE_TABLE_BITS - 2);
	localparam int unsigned QIDX_W          = SINE_TABLE_BITS - 1;
	localparam int unsigned ENV_IDX_W       = $clog2(RAMP_LEN + 1);

	localparam int unsigned PHASE_W  = 32;
	localparam int unsigned LEN_W    = 23;
	localparam int unsigned RATE_W   = 17;
	localparam int unsigned DUR_W    = 16;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned MAG_W    = 15;
	localparam int unsigned ENV_W    = 16;
	localparam int unsigned ENV_FRAC = 15;
	localparam int unsigned PROD_W   = DUR_W + RATE_W;
	localparam int unsigned QUOT_W   = 24;

	// Division by 1000 as a shift by 3 and a multiply by ceil(2^37 / 125).
	// The quotient is exact for every dividend below 2^30.
	localparam int unsigned DIV_PRE_SHIFT = 3;
	localparam int unsigned DIV_IN_W      = PROD_W - DIV_PRE_SHIFT;
	localparam int unsigned RECIP_W       = 31;
	localparam int unsigned RECIP_SHIFT   = 37;
	localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;

	localparam int unsigned MS_PER_S       = 1000;
	localparam int unsigned TONE_AMPLITUDE = 24576;
	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
	localparam logic [63:0] ONE_Q30        = 64'd1 << 30;

	localparam logic [LEN_W-1:0]    LEN_MAX    = '1;
	localparam logic [RATE_W-1:0]   RATE_RESET = 17'd44100;
	localparam logic [ENV_W-1:0]    ENV_ONE    = 16'h8000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd24576;

	// Request kinds carried on the input tuser
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_TONE  = 2'd1;
	localparam logic [1:0] REQ_PAUSE = 2'd2;

	// Microprogram addresses
	localparam int unsigned STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FETCH = 3'd0;
	localparam logic [STEP_W-1:0] STEP_MUL1  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_MUL2  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_PROD  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_DIV   = 3'd5;
	localparam logic [STEP_W-1:0] STEP_FIN   = 3'd6;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_FETCH,
		OP_MUL1,
		OP_MUL2,
		OP_EMIT,
		OP_PROD,
		OP_DIV,
		OP_FIN
	} dp_op_t;

	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_GOTO,
		JMP_DISPATCH,
		JMP_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		logic              in_rdy;
		dp_op_t            op;
		jmp_t              jmp;
		logic [STEP_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic   in_rdy;
		dp_op_t op;
	} ctrl_t;

	typedef logic [MAG_W-1:0] qtab_t [QUARTER+1];
	typedef logic [ENV_W-1:0] etab_t [RAMP_LEN+1];

	// Taylor series of sin(x) to x^13, x and result in Q30
	function automatic logic [63:0] sin_series(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 110;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 156;
		sum  = sum + term;
		return sum;
	endfunction

	function automatic qtab_t build_quarter_tab();
		qtab_t       tab;
		logic [63:0] s;
		for (int k = 0; k <= QUARTER; k++) begin
			if (k >= QUARTER) begin
				s = ONE_Q30;
			end else begin
				s = sin_series((64'(k) * HALF_PI_Q30) / QUARTER);
			end
			tab[k] = MAG_W'((64'(TONE_AMPLITUDE) * s) >> 30);
		end
		return tab;
	endfunction

	function automatic etab_t build_env_tab();
		etab_t       tab;
		logic [63:0] s;
		for (int m = 0; m <= RAMP_LEN; m++) begin
			if (m >= RAMP_LEN) begin
				s = ONE_Q30;
			end else begin
				s = sin_series((64'(m) * HALF_PI_Q30) / RAMP_LEN);
			end
			tab[m] = ENV_W'(s >> 15);
		end
		return tab;
	endfunction

	localparam qtab_t QUARTER_TAB = build_quarter_tab();
	localparam etab_t ENV_TAB     = build_env_tab();

endpackage

`default_nettype wire

// File: design/sstg_ucode_rom.sv
`default_nettype none

module sstg_ucode_rom
	import sstg_pkg::*;
(
	input  wire logic [STEP_W-1:0] pc,
	output uword_t                 uword
);

	// Control store: one word per step of the program
	always_comb begin
		uword = '{in_rdy: 1'b0, op: OP_NOP, jmp: JMP_GOTO, target: STEP_FETCH};
		unique case (pc)
			STEP_FETCH: begin
				uword = '{in_rdy: 1'b1, op: OP_FETCH, jmp: JMP_DISPATCH,
					target: STEP_FETCH};
			end
			STEP_MUL1: begin
				uword = '{in_rdy: 1'b0, op: OP_MUL1, jmp: JMP_NEXT,
					target: STEP_FETCH};
			end
			STEP_MUL2: begin
				uword = '{in_rdy: 1'b0, op: OP_MUL2, jmp: JMP_NEXT,
					target: STEP_FETCH};
			end
			STEP_EMIT: begin
				uword = '{in_rdy: 1'b0, op: OP_EMIT, jmp: JMP_WAIT_OUT,
					target: STEP_FETCH};
			end
			STEP_PROD: begin
				uword = '{in_rdy: 1'b0, op: OP_PROD, jmp: JMP_NEXT,
					target: STEP_FETCH};
			end
			STEP_DIV: begin
				uword = '{in_rdy: 1'b0, op: OP_DIV, jmp: JMP_NEXT,
					target: STEP_FETCH};
			end
			STEP_FIN: begin
				uword = '{in_rdy: 1'b0, op: OP_FIN, jmp: JMP_GOTO,
					target: STEP_FETCH};
			end
			default: begin
				uword = '{in_rdy: 1'b0, op: OP_NOP, jmp: JMP_GOTO,
					target: STEP_FETCH};
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/sstg_sequencer.sv
`default_nettype none

module sstg_sequencer
	import sstg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [1:0] req_type,
	input  wire logic       out_free,
	output ctrl_t           ctrl
);

	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_next;
	uword_t            uword;

	sstg_ucode_rom u_rom (
		.pc    (pc_q),
		.uword (uword)
	);

	assign ctrl = '{in_rdy: uword.in_rdy, op: uword.op};

	// Next step address from the jump field of the current word
	always_comb begin
		pc_next = pc_q;
		unique case (uword.jmp)
			JMP_NEXT: pc_next = pc_q + 1'b1;
			JMP_GOTO: pc_next = uword.target;
			JMP_DISPATCH: begin
				if (accept) begin
					unique case (req_type)
						REQ_TICK:  pc_next = STEP_MUL1;
						REQ_TONE:  pc_next = STEP_PROD;
						REQ_PAUSE: pc_next = STEP_PROD;
						default:   pc_next = STEP_FETCH;
					endcase
				end
			end
			JMP_WAIT_OUT: begin
				if (out_free) begin
					pc_next = uword.target;
				end
			end
			default: pc_next = STEP_FETCH;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

`default_nettype wire

// File: design/sstg_datapath.sv
`default_nettype none

module sstg_datapath
	import sstg_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ctrl_t                      ctrl,
	input  wire logic                       accept,
	input  wire logic [1:0]                 req_type,
	input  wire logic [DUR_W-1:0]           duration_ms,
	input  wire logic [PHASE_W-1:0]         phase_step,
	input  wire logic                       cfg_valid,
	input  wire logic [RATE_W-1:0]          cfg_data,
	input  wire logic                       out_ready,
	output logic                            out_free,
	output logic                            out_valid,
	output logic signed [SAMPLE_W-1:0]      out_sample,
	output logic                            out_last,
	output logic                            out_idle
);

	// Element state
	logic [RATE_W-1:0]  rate_q;
	logic [PHASE_W-1:0] phase_acc_q;
	logic [PHASE_W-1:0] step_hold_q;
	logic [LEN_W-1:0]   index_q;
	logic [LEN_W-1:0]   len_q;
	logic               active_q;
	logic               tone_q;
	logic [DUR_W-1:0]   dur_q;

	// Length computation
	logic [PROD_W-1:0]  prod_q;
	logic [QUOT_W-1:0]  quot_q;

	// Sample path
	logic [MAG_W-1:0]   mag_s1;
	logic               neg_s1;
	logic [ENV_W-1:0]   e1_s1;
	logic [ENV_W-1:0]   e2_s1;
	logic               last_s1;
	logic               idle_s1;
	logic [MAG_W-1:0]   mag_s2;
	logic [MAG_W-1:0]   mag_s3;

	// Output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_last_q;
	logic                       out_idle_q;

	logic [SINE_TABLE_BITS-1:0] tab_idx;
	logic [1:0]                 quad;
	logic [QIDX_W-2:0]          off;
	logic [QIDX_W-1:0]          qaddr;
	logic [MAG_W-1:0]           tab_mag;
	logic                       rise;
	logic                       fall;
	logic [LEN_W-1:0]           len_left;
	logic                       is_last;
	logic [ENV_W-1:0]           e1;
	logic [ENV_W-1:0]           e2;
	logic [MAG_W-1:0]           mul_a;
	logic [ENV_W-1:0]           mul_b;
	logic [MAG_W+ENV_W-1:0]     mul_p;
	logic [MAG_W-1:0]           mul_scaled;
	logic [DIV_IN_W+RECIP_W-1:0] recip_p;
	logic signed [SAMPLE_W-1:0] mag_signed;
	logic                       emit;

	assign out_free  = !out_valid_q || out_ready;
	assign emit      = (ctrl.op == OP_EMIT) && out_free;
	assign out_valid = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_last  = out_last_q;
	assign out_idle  = out_idle_q;

	// Quarter-wave lookup, mirrored in index and sign by the quadrant
	assign tab_idx = phase_acc_q[PHASE_W-1 -: SINE_TABLE_BITS];
	assign quad    = tab_idx[SINE_TABLE_BITS-1 -: 2];
	assign off     = tab_idx[SINE_TABLE_BITS-3:0];
	assign qaddr   = quad[0] ? (QIDX_W'(QUARTER) - {1'b0, off}) : {1'b0, off};
	assign tab_mag = QUARTER_TAB[qaddr];

	// Envelope selection: rise over the first samples, fall over the last
	assign rise     = index_q < LEN_W'(RAMP_LEN);
	assign fall     = (len_q >= LEN_W'(RAMP_LEN)) &&
		(({1'b0, index_q} + (LEN_W+1)'(RAMP_LEN)) > {1'b0, len_q});
	assign len_left = len_q - index_q;
	assign e1       = rise ? ENV_TAB[index_q[ENV_IDX_W-1:0]] : ENV_ONE;
	assign e2       = fall ? ENV_TAB[len_left[ENV_IDX_W-1:0]] : ENV_ONE;
	assign is_last  = ({1'b0, index_q} + 1'b1) >= {1'b0, len_q};

	// One shared envelope multiplier, Q15 scaling truncates the magnitude
	assign mul_a      = (ctrl.op == OP_MUL1) ? mag_s1 : mag_s2;
	assign mul_b      = (ctrl.op == OP_MUL1) ? e1_s1 : e2_s1;
	assign mul_p      = mul_a * mul_b;
	assign mul_scaled = mul_p[MAG_W+ENV_FRAC-1 : ENV_FRAC];

	// Divide by 1000: drop the factor of 8, then multiply by the scaled reciprocal of 125
	assign recip_p = prod_q[PROD_W-1:DIV_PRE_SHIFT] * RECIP_125;

	assign mag_signed = $signed({1'b0, mag_s3});

	// Control and element state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= RATE_RESET;
			phase_acc_q <= '0;
			step_hold_q <= '0;
			index_q     <= '0;
			len_q       <= '0;
			active_q    <= 1'b0;
			tone_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				rate_q <= cfg_data;
			end
			if (ctrl.op == OP_FETCH && accept &&
				(req_type == REQ_TONE || req_type == REQ_PAUSE)) begin
				phase_acc_q <= '0;
				step_hold_q <= phase_step;
				index_q     <= '0;
				tone_q      <= (req_type == REQ_TONE);
				active_q    <= 1'b0;
			end
			if (ctrl.op == OP_FIN) begin
				len_q    <= (quot_q[QUOT_W-1:LEN_W] != '0) ? LEN_MAX : quot_q[LEN_W-1:0];
				active_q <= (quot_q != '0);
			end
			if (emit && active_q) begin
				phase_acc_q <= phase_acc_q + step_hold_q;
				index_q     <= index_q + 1'b1;
				if (last_s1) begin
					active_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_FETCH: begin
				mag_s1  <= (active_q && tone_q) ? tab_mag : '0;
				neg_s1  <= quad[1];
				e1_s1   <= e1;
				e2_s1   <= e2;
				last_s1 <= active_q && is_last;
				idle_s1 <= !active_q;
				if (accept) begin
					dur_q <= duration_ms;
				end
			end
			OP_MUL1: mag_s2 <= mul_scaled;
			OP_MUL2: mag_s3 <= mul_scaled;
			OP_EMIT: begin
				if (emit) begin
					out_sample_q <= neg_s1 ? -mag_signed : mag_signed;
					out_last_q   <= last_s1;
					out_idle_q   <= idle_s1;
				end
			end
			OP_PROD: begin
				prod_q <= PROD_W'(dur_q) * PROD_W'(rate_q);
			end
			OP_DIV: begin
				quot_q <= recip_p[RECIP_SHIFT +: QUOT_W];
			end
			OP_FIN: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/shaped_sine_tone_generator_top.sv
`default_nettype none

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: req_type; tdata: duration_ms,
//                                                     phase_step
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: sample; tlast: last; tuser: idle
// cfg       in         cfg_valid / cfg_ready          cfg_data: sample_rate
//
// A sample tick runs through the fetch with table lookup, two passes through the
// shared envelope multiplier, and the emit step into the output register.
// A start runs through fetch, duration times rate, a reciprocal multiply that
// divides by 1000, and the length update.
// Reset is asynchronous and leaves the generator idle with a sample rate of 44100.
// The output register holds one item; the emit step waits while it is full and m_axis_tready is low.
module shaped_sine_tone_generator_top
	import sstg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [47:0]        s_axis_tdata,  // [15:0] duration_ms, [47:16] phase_step
	input  wire logic [1:0]         s_axis_tuser,  // [1:0] req_type
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [SAMPLE_W-1:0]     m_axis_tdata,  // [15:0] sample
	output logic                    m_axis_tlast,
	output logic                    m_axis_tuser,  // [0] idle
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [RATE_W-1:0]  cfg_data
);

	ctrl_t                      ctrl;
	logic                       accept;
	logic                       out_free;
	logic signed [SAMPLE_W-1:0] sample;

	assign s_axis_tready = ctrl.in_rdy;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tdata  = sample;

	sstg_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req_type (s_axis_tuser),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	sstg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.accept      (accept),
		.req_type    (s_axis_tuser),
		.duration_ms (s_axis_tdata[DUR_W-1:0]),
		.phase_step  (s_axis_tdata[DUR_W+PHASE_W-1:DUR_W]),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.out_ready   (m_axis_tready),
		.out_free    (out_free),
		.out_valid   (m_axis_tvalid),
		.out_sample  (sample),
		.out_last    (m_axis_tlast),
		.out_idle    (m_axis_tuser)
	);

`ifndef ASSERT_OFF
	// An idle item carries silence and never ends an element
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0 && !m_axis_tlast))
		else $error("idle item with nonzero sample or last set");

	// An accepted tick goes straight into the first envelope multiply
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tuser == REQ_TICK) |=> (ctrl.op == OP_MUL1))
		else $error("tick not followed by envelope multiply");

	// Samples stay within the tone amplitude
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (sample <= SAMPLE_MAX && sample >= -SAMPLE_MAX))
		else $error("sample beyond tone amplitude");
`endif

endmodule

`default_nettype wire
